[design/kmp_pattern_search_macros.svh]
`ifndef KMP_PATTERN_SEARCH_MACROS_SVH
`define KMP_PATTERN_SEARCH_MACROS_SVH

// same-cycle implication check
`define KPS_ASSERT_IMP(name, clock, reset, pre, post) \
  name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
    else $error("kmp_pattern_search: check failed");

// next-cycle implication check
`define KPS_ASSERT_NEXT(name, clock, reset, pre, post) \
  name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
    else $error("kmp_pattern_search: check failed");

`endif

[design/kps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package kps_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } op_t;

  localparam int REG_INDEX_BITS = 1;
  localparam logic [REG_INDEX_BITS-1:0] REG_CASE_FOLD      = 1'b0;
  localparam logic [REG_INDEX_BITS-1:0] REG_START_POSITION = 1'b1;

  // ascii upper-case range and the offset to lower case
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_CASE_GAP = 8'h20;

  typedef struct packed {
    logic clear_pattern;
    logic app_start;
    logic txt_start;
    logic txt_skip;
    logic pfx_load;
    logic pfx_step;
    logic app_finish;
    logic txt_finish;
    logic end_item;
    logic calc_pos;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic len_zero;
    logic len_full;
    logic done;
    logic eq;
    logic k_zero;
    logic hit;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

[design/kmp_pattern_search.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "kmp_pattern_search_macros.svh"

// channel   handshake                 beat contents
// item      item_valid / item_stall   operation, character
// result    result_valid / result_stall  found, match_position
// config    write_enable              register_index, write_data
//
// text beat: compare plus load/compare per link step; skipped after a match or no pattern
// append: start, load, compare, more load/compare per link; clear, first, ignored char: idle
// end of text: idle, then output unless a match was found; a match adds position and output
// reset clears control and config state; pattern and prefix memories need no clearing pass
// a stalled result holds the block once the next result is ready; new beats wait meanwhile

module kmp_pattern_search #(
  parameter int MAX_PATTERN   = 256,
  parameter int CHAR_BITS     = 16,
  parameter int POSITION_BITS = 24
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               item_valid,
  output logic                                    item_stall,
  input  wire logic [1:0]                         operation,
  input  wire logic [CHAR_BITS-1:0]               character,
  output logic                                    result_valid,
  input  wire logic                               result_stall,
  output logic                                    found,
  output logic [POSITION_BITS-1:0]                match_position,
  input  wire logic                               write_enable,
  input  wire logic [kps_pkg::REG_INDEX_BITS-1:0] register_index,
  input  wire logic [POSITION_BITS-1:0]           write_data
);

  kps_pkg::cmd_t    cmd;
  kps_pkg::status_t status;

  kps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .operation  (operation),
    .status     (status),
    .cmd        (cmd)
  );

  kps_datapath #(
    .MAX_PATTERN   (MAX_PATTERN),
    .CHAR_BITS     (CHAR_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .character      (character),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .found          (found),
    .match_position (match_position)
  );

  // output register is only loaded when its beat has gone or is leaving
  `KPS_ASSERT_IMP(a_emit_slot_free, clk, rst, cmd.emit, !result_valid || !result_stall)
  // the controller issues at most one command per cycle
  `KPS_ASSERT_IMP(a_single_cmd, clk, rst, 1'b1, $onehot0(cmd))
  // not-found beats carry a zero position
  `KPS_ASSERT_IMP(a_not_found_zero, clk, rst, result_valid && !found, match_position == '0)
  // a completed match keeps the item side stalled while the position is formed
  `KPS_ASSERT_NEXT(a_match_holds_input, clk, rst, cmd.txt_finish && status.hit, item_stall)

endmodule

`default_nettype wire

[design/kps_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module kps_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_stall,
  input  wire logic [1:0]     operation,
  input  wire kps_pkg::status_t status,
  output kps_pkg::cmd_t       cmd
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_APP_PFX = 7'b0000010,
    S_APP_CMP = 7'b0000100,
    S_TXT_PFX = 7'b0001000,
    S_TXT_CMP = 7'b0010000,
    S_POS     = 7'b0100000,
    S_EMIT    = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  kps_pkg::op_t op;

  assign op = kps_pkg::op_t'(operation);
  assign item_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          case (op)
            kps_pkg::OP_CLEAR: begin
              cmd.clear_pattern = 1'b1;
            end
            kps_pkg::OP_APPEND: begin
              // a full pattern ignores the character
              if (!status.len_full) begin
                cmd.app_start = 1'b1;
                if (!status.len_zero) begin
                  state_next = S_APP_PFX;
                end
              end
            end
            kps_pkg::OP_TEXT: begin
              if (status.done || status.len_zero) begin
                cmd.txt_skip = 1'b1;
              end else begin
                cmd.txt_start = 1'b1;
                state_next = S_TXT_CMP;
              end
            end
            kps_pkg::OP_END: begin
              cmd.end_item = 1'b1;
              if (!status.done) begin
                state_next = S_EMIT;
              end
            end
            default: begin
              cmd = '0;
            end
          endcase
        end
      end
      S_APP_PFX: begin
        cmd.pfx_load = 1'b1;
        state_next = S_APP_CMP;
      end
      S_APP_CMP: begin
        if (status.eq || status.k_zero) begin
          cmd.app_finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.pfx_step = 1'b1;
          state_next = S_APP_PFX;
        end
      end
      S_TXT_PFX: begin
        cmd.pfx_load = 1'b1;
        state_next = S_TXT_CMP;
      end
      S_TXT_CMP: begin
        if (status.eq || status.k_zero) begin
          cmd.txt_finish = 1'b1;
          state_next = status.hit ? S_POS : S_IDLE;
        end else begin
          cmd.pfx_step = 1'b1;
          state_next = S_TXT_PFX;
        end
      end
      S_POS: begin
        cmd.calc_pos = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[design/kps_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module kps_datapath #(
  parameter int MAX_PATTERN   = 256,
  parameter int CHAR_BITS     = 16,
  parameter int POSITION_BITS = 24
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire kps_pkg::cmd_t                       cmd,
  output kps_pkg::status_t                         status,
  input  wire logic [CHAR_BITS-1:0]                character,
  input  wire logic                                write_enable,
  input  wire logic [kps_pkg::REG_INDEX_BITS-1:0]  register_index,
  input  wire logic [POSITION_BITS-1:0]            write_data,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output logic                                     found,
  output logic [POSITION_BITS-1:0]                 match_position
);

  localparam int IDX_BITS = $clog2(MAX_PATTERN);
  localparam int LEN_BITS = $clog2(MAX_PATTERN + 1);
  localparam int OFF_BITS = (POSITION_BITS + 1 > LEN_BITS) ? POSITION_BITS + 1 : LEN_BITS;

  function automatic logic [CHAR_BITS-1:0] fold(input logic [CHAR_BITS-1:0] c,
                                                input logic mode);
    if (mode && c >= CHAR_BITS'(kps_pkg::ASCII_UPPER_A)
             && c <= CHAR_BITS'(kps_pkg::ASCII_UPPER_Z)) begin
      fold = c + CHAR_BITS'(kps_pkg::ASCII_CASE_GAP);
    end else begin
      fold = c;
    end
  endfunction

  logic [CHAR_BITS-1:0] pattern_mem [MAX_PATTERN];
  logic [IDX_BITS-1:0]  prefix_mem  [MAX_PATTERN];

  logic                     case_fold;
  logic [POSITION_BITS-1:0] start_position;
  logic [LEN_BITS-1:0]      pattern_length;
  logic [LEN_BITS-1:0]      kreg;
  logic [POSITION_BITS-1:0] text_count;
  logic                     search_done;
  logic [CHAR_BITS-1:0]     fc;
  logic [POSITION_BITS-1:0] offset;
  logic                     res_found;
  logic [POSITION_BITS-1:0] res_pos;
  logic [CHAR_BITS-1:0]     pat_q;
  logic [IDX_BITS-1:0]      pfx_q;

  logic                     len_zero;
  logic                     eq;
  logic [LEN_BITS-1:0]      k_inc;
  logic [LEN_BITS-1:0]      k_dec;
  logic [LEN_BITS-1:0]      n_dec;
  logic [LEN_BITS-1:0]      k_new;
  logic                     hit;
  logic [IDX_BITS-1:0]      pat_raddr;
  logic [IDX_BITS-1:0]      pfx_raddr;
  logic                     pfx_we;
  logic [IDX_BITS-1:0]      pfx_wdata;
  logic                     restart;
  logic [POSITION_BITS-1:0] tc_next;
  logic [OFF_BITS-1:0]      idx_one;
  logic [OFF_BITS-1:0]      len_wide;
  logic [OFF_BITS-1:0]      off_wide;
  logic [POSITION_BITS:0]   pos_sum;
  logic [POSITION_BITS-1:0] pos_sat;
  logic                     out_free;

  assign len_zero = (pattern_length == '0);
  assign eq       = (fold(pat_q, case_fold) == fc);
  assign k_inc    = kreg + LEN_BITS'(1);
  assign k_dec    = kreg - LEN_BITS'(1);
  assign n_dec    = pattern_length - LEN_BITS'(1);
  assign k_new    = eq ? k_inc : '0;
  assign hit      = (k_new >= pattern_length);

  // after a failure link the next pattern read follows the table output
  assign pat_raddr = cmd.pfx_load ? pfx_q : kreg[IDX_BITS-1:0];
  assign pfx_raddr = cmd.pfx_step ? k_dec[IDX_BITS-1:0] : n_dec[IDX_BITS-1:0];
  assign pfx_we    = (cmd.app_start && len_zero) || cmd.app_finish;
  assign pfx_wdata = cmd.app_finish ? k_new[IDX_BITS-1:0] : '0;

  assign restart = cmd.clear_pattern || (cmd.app_start && len_zero)
                || cmd.app_finish || cmd.end_item;

  assign tc_next = (&text_count) ? text_count : text_count + POSITION_BITS'(1);

  // match start relative to the text, taken from the index before the bump
  assign idx_one  = OFF_BITS'(text_count) + OFF_BITS'(1);
  assign len_wide = OFF_BITS'(pattern_length);
  assign off_wide = (idx_one >= len_wide) ? idx_one - len_wide : '0;

  assign pos_sum = {1'b0, start_position} + {1'b0, offset};
  assign pos_sat = pos_sum[POSITION_BITS] ? '1 : pos_sum[POSITION_BITS-1:0];

  assign out_free = !result_valid || !result_stall;

  assign status.len_zero = len_zero;
  assign status.len_full = (pattern_length == LEN_BITS'(MAX_PATTERN));
  assign status.done     = search_done;
  assign status.eq       = eq;
  assign status.k_zero   = (kreg == '0);
  assign status.hit      = hit;
  assign status.out_free = out_free;

  always_ff @(posedge clk) begin
    if (cmd.app_start) begin
      pattern_mem[pattern_length[IDX_BITS-1:0]] <= character;
    end
    pat_q <= pattern_mem[pat_raddr];
  end

  always_ff @(posedge clk) begin
    if (pfx_we) begin
      prefix_mem[pattern_length[IDX_BITS-1:0]] <= pfx_wdata;
    end
    pfx_q <= prefix_mem[pfx_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.app_start || cmd.txt_start) begin
      fc <= fold(character, case_fold);
    end
    if (cmd.txt_start) begin
      offset <= off_wide[POSITION_BITS-1:0];
    end
    if (cmd.end_item) begin
      res_found <= len_zero;
      res_pos   <= len_zero ? start_position : '0;
    end else if (cmd.calc_pos) begin
      res_found <= 1'b1;
      res_pos   <= pos_sat;
    end
    if (cmd.emit) begin
      found          <= res_found;
      match_position <= res_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      case_fold      <= 1'b0;
      start_position <= '0;
      pattern_length <= '0;
      kreg           <= '0;
      text_count     <= '0;
      search_done    <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (write_enable) begin
        case (register_index)
          kps_pkg::REG_CASE_FOLD:      case_fold      <= write_data[0];
          kps_pkg::REG_START_POSITION: start_position <= write_data;
          default: begin
          end
        endcase
      end

      if (cmd.clear_pattern) begin
        pattern_length <= '0;
      end else if (cmd.app_start && len_zero) begin
        pattern_length <= LEN_BITS'(1);
      end else if (cmd.app_finish) begin
        pattern_length <= pattern_length + LEN_BITS'(1);
      end

      if (restart) begin
        kreg <= '0;
      end else if (cmd.pfx_load) begin
        kreg <= LEN_BITS'(pfx_q);
      end else if (cmd.txt_finish) begin
        kreg <= hit ? '0 : k_new;
      end

      if (restart) begin
        text_count <= '0;
      end else if (cmd.txt_start || cmd.txt_skip) begin
        text_count <= tc_next;
      end

      if (restart) begin
        search_done <= 1'b0;
      end else if (cmd.txt_finish && hit) begin
        search_done <= 1'b1;
      end

      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[tb/kmp_pattern_search_tb.sv]
`timescale 1ns / 1ps

module kmp_pattern_search_tb;
  import kps_pkg::*;

  localparam int PATTERN_DEPTH = 256;
  localparam int CHAR_W = 16;
  localparam int POS_W = 24;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam int ITEM_TARGET = 1350;
  localparam int NUM_PHASES = 7;
  localparam int SETTLE_CYCLES = 600;
  localparam int LONG_HOLD = 400;
  localparam int CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } search_result_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic              typed;
    logic              has_result;
    logic              found;
    logic [POS_W-1:0]  position;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [1:0] operation = OP_CLEAR;
  logic [CHAR_W-1:0] character = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic found;
  logic [POS_W-1:0] match_position;
  logic write_enable = 1'b0;
  logic [REG_INDEX_BITS-1:0] register_index = REG_CASE_FOLD;
  logic [POS_W-1:0] write_data = '0;

  // search state tracked alongside the block
  logic [CHAR_W-1:0] pat_chars [PATTERN_DEPTH];
  logic [7:0] fail_link [PATTERN_DEPTH];
  int pat_len;
  int match_len;
  logic [POS_W-1:0] text_index;
  bit hit_seen;
  bit fold_mode;
  logic [POS_W-1:0] base_position;

  search_result_t pending_matches [$];
  int mismatches = 0;
  int items_sent = 0;
  int burst_left = 0;
  int cycle_count = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  bit long_hold_req = 1'b0;

  bit fold_plan [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  logic [POS_W-1:0] start_plan [NUM_PHASES];

  stim_row_t directed_rows [24] = '{
    '{OP_END,    16'h0000, 1'b1, 1'b1, 1'b1, 24'd0},
    '{OP_TEXT,   16'h0061, 1'b1, 1'b0, 1'b0, 24'd0},
    '{OP_APPEND, 16'hFFFF, 1'b0, 1'b0, 1'b0, 24'd0},
    '{OP_APPEND, 16'h0000, 1'b0, 1'b0, 1'b0, 24'd0},
    '{OP_TEXT,   16'h0000, 1'b0, 1'b0, 1'b0, 24'd0},
    '{OP_TEXT,   16'hFFFF, 1'b0, 1'b0, 1'b0, 24'd0},
    '{OP_TEXT,   16'h0000, 1'b0, 1'b0, 1'b0, 24'd0},
    '{OP_TEXT,   16'h0000, 1'b1, 1'b0, 1'b0, 24'd0},
    '{OP_END,    16'h0000, 1'b1, 1'b0, 1'b0, 24'd0},
    '{OP_END,    16'hFFFF, 1'b1, 1'b1, 1'b0, 24'd0},
    '{OP_CLEAR,  16'hFFFF, 1'b0, 1'b0, 1'b0, 24'd0},
    '{OP_APPEND, 16'h0041, 1'b0, 1'b0, 1'b0, 24'd0},
    '{OP_APPEND, 16'h0041, 1'b0, 1'b0, 1'b0, 24'd0},
    '{OP_APPEND, 16'h0042, 1'b0, 1'b0, 1'b0, 24'd0},
    '{OP_TEXT,   16'h0061, 1'b0, 1'b0, 1'b0, 24'd0},
    '{OP_TEXT,   16'h0041, 1'b0, 1'b0, 1'b0, 24'd0},
    '{OP_TEXT,   16'h0041, 1'b0, 1'b0, 1'b0, 24'd0},
    '{OP_TEXT,   16'h0041, 1'b0, 1'b0, 1'b0, 24'd0},
    '{OP_TEXT,   16'h0042, 1'b0, 1'b0, 1'b0, 24'd0},
    '{OP_END,    16'h0000, 1'b1, 1'b0, 1'b0, 24'd0},
    '{OP_TEXT,   16'h0041, 1'b0, 1'b0, 1'b0, 24'd0},
    '{OP_END,    16'h0000, 1'b1, 1'b1, 1'b0, 24'd0},
    '{OP_CLEAR,  16'h0000, 1'b0, 1'b0, 1'b0, 24'd0},
    '{OP_END,    16'h0000, 1'b1, 1'b1, 1'b1, 24'd0}
  };

  kmp_pattern_search dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .operation      (operation),
    .character      (character),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .found          (found),
    .match_position (match_position),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [CHAR_W-1:0] fold_ascii(input logic [CHAR_W-1:0] c, input bit mode);
    if (mode && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) return c + ASCII_CASE_GAP;
    return c;
  endfunction

  function automatic void restart_search();
    match_len = 0;
    text_index = '0;
    hit_seen = 1'b0;
  endfunction

  // returns 1 when the beat yields a result, which lands in res
  function automatic bit predict_search(input op_t op, input logic [CHAR_W-1:0] ch,
                                        output search_result_t res);
    logic [CHAR_W-1:0] fc;
    logic [POS_W-1:0] idx;
    longint sum;
    int k;
    int n;
    int off;
    bit produced;
    res = '0;
    produced = 1'b0;
    fc = fold_ascii(ch, fold_mode);
    case (op)
      OP_CLEAR: begin
        pat_len = 0;
        restart_search();
      end
      OP_APPEND: begin
        // a full pattern drops the character and keeps the search state
        if (pat_len < PATTERN_DEPTH) begin
          n = pat_len;
          pat_chars[n] = ch;
          if (n == 0) begin
            fail_link[0] = '0;
          end else begin
            k = fail_link[n-1];
            while (k != 0 && fold_ascii(pat_chars[k], fold_mode) != fc) k = fail_link[k-1];
            if (fold_ascii(pat_chars[k], fold_mode) == fc) k++;
            fail_link[n] = k[7:0];
          end
          pat_len = n + 1;
          restart_search();
        end
      end
      OP_TEXT: begin
        k = match_len;
        idx = text_index;
        if (text_index != POS_MAX) text_index++;
        if (!hit_seen && pat_len != 0) begin
          while (k != 0 && fold_ascii(pat_chars[k], fold_mode) != fc) k = fail_link[k-1];
          if (fold_ascii(pat_chars[k], fold_mode) == fc) k++;
          if (k >= pat_len) begin
            off = (int'(idx) + 1 >= pat_len) ? int'(idx) + 1 - pat_len : 0;
            sum = longint'(base_position) + off;
            res.found = 1'b1;
            res.position = (sum > POS_MAX) ? POS_MAX : sum[POS_W-1:0];
            hit_seen = 1'b1;
            produced = 1'b1;
            k = 0;
          end
          match_len = k;
        end
      end
      default: begin
        if (!hit_seen) begin
          produced = 1'b1;
          res.found = (pat_len == 0);
          res.position = (pat_len == 0) ? base_position : '0;
        end
        restart_search();
      end
    endcase
    return produced;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_symbol();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5:
        return 16'h0041 + 16'($urandom_range(0, 2)) + ($urandom_range(0, 1) ? 16'h0020 : 16'h0000);
      6: begin
        // characters just outside the folded range, and one with a high byte
        case ($urandom_range(0, 4))
          0: return 16'h0040;
          1: return 16'h005B;
          2: return 16'h0060;
          3: return 16'h007B;
          default: return 16'h0141;
        endcase
      end
      7: return 16'($urandom_range(0, 65535));
      8: return $urandom_range(0, 1) ? 16'h005A : 16'h007A;
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic send_item(input op_t op, input logic [CHAR_W-1:0] ch, input bit typed = 1'b0,
                           input bit typed_has = 1'b0, input search_result_t typed_res = '0);
    int gap;
    bit produced;
    search_result_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 30);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    operation <= op;
    character <= ch;
    do @(posedge clk); while (item_stall);
    produced = predict_search(op, ch, res);
    if (typed) begin
      produced = typed_has;
      res = typed_res;
    end
    if (produced) pending_matches.push_back(res);
    items_sent++;
  endtask

  // beats with no result may still be in flight once the queue is empty
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input bit fold, input logic [POS_W-1:0] start);
    write_enable <= 1'b1;
    register_index <= REG_CASE_FOLD;
    write_data <= POS_W'(fold);
    @(posedge clk);
    register_index <= REG_START_POSITION;
    write_data <= start;
    @(posedge clk);
    write_enable <= 1'b0;
    fold_mode = fold;
    base_position = start;
  endtask

  task automatic run_sequence(input bit full_length);
    int len;
    int n;
    logic [CHAR_W-1:0] c;
    bit embed;
    if (!full_length && $urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4))
        send_item(op_t'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
      return;
    end
    if (full_length || $urandom_range(0, 4) != 0) send_item(OP_CLEAR, 16'($urandom));
    if (full_length) len = PATTERN_DEPTH + $urandom_range(1, 4);
    else if ($urandom_range(0, 7) == 0) len = $urandom_range(8, 24);
    else len = $urandom_range(0, 6);
    repeat (len) send_item(OP_APPEND, pick_symbol());
    embed = full_length || $urandom_range(0, 9) < 7;
    repeat ($urandom_range(0, 8)) send_item(OP_TEXT, pick_symbol());
    if (embed) begin
      n = pat_len;
      for (int i = 0; i < n; i++) begin
        c = pat_chars[i];
        // swap letter case now and then so folding matters
        if ($urandom_range(0, 3) == 0 &&
            ((c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A)))
          c = c ^ 16'(ASCII_CASE_GAP);
        if (!full_length && $urandom_range(0, 19) == 0) c = pick_symbol();
        send_item(OP_TEXT, c);
      end
    end
    repeat ($urandom_range(0, 4)) send_item(OP_TEXT, pick_symbol());
    if (full_length || $urandom_range(0, 19) != 0) send_item(OP_END, 16'($urandom));
  endtask

  // result side stalls on its own pattern, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD;
      result_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        default: result_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    search_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_matches.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat found=%0b position=%0h",
                                  found, match_position));
      end else begin
        want = pending_matches.pop_front();
        if (found !== want.found)
          report_mismatch($sformatf("found %0b, want %0b", found, want.found));
        if (match_position !== want.position)
          report_mismatch($sformatf("position %0h, want %0h", match_position, want.position));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    fold_mode = 1'b0;
    base_position = '0;
    pat_len = 0;
    restart_search();
    start_plan = '{24'd0, POS_MAX, POS_MAX - 24'd15, 24'($urandom_range(1, 24'hFFFFFE)),
                   24'($urandom_range(1, 24'hFFFFFE)), 24'd0, POS_MAX};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].typed,
                directed_rows[i].has_result,
                search_result_t'({directed_rows[i].found, directed_rows[i].position}));

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      set_config(fold_plan[p], start_plan[p]);
      if (p == 1) long_hold_req = 1'b1;
      if (p == 3) run_sequence(1'b1);
      while (items_sent < ITEM_TARGET * (p + 1) / NUM_PHASES) run_sequence(1'b0);
    end
    wait_idle();

    if (mismatches == 0 && pending_matches.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/kps_pkg.sv
design/kps_ctrl.sv
design/kps_datapath.sv
design/kmp_pattern_search.sv
tb/kmp_pattern_search_tb.sv
